>>> design/pat_pkg.sv
`default_nettype none

package pat_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned POS_W  = 4;
	localparam int unsigned DATA_W = 32;

	// Request codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_REVERSE = 3'd2,
		OP_SEARCH  = 3'd3,
		OP_READ    = 3'd4
	} op_t;

endpackage

`default_nettype wire

>>> design/pat_ram.sv
`default_nettype none

module pat_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/positional_array_table_core.sv
`default_nettype none

// Positional table of DEPTH signed 32-bit entries, all zero after reset, kept in
// one RAM with a registered read port. Each request word carries an operation
// (insert, delete, reverse, search, read), a 1-based position and a value, and
// gives exactly one response word. A position outside 1..DEPTH for insert,
// delete or read leaves the table alone and raises position_error. Requests are
// served one at a time: req_stall is high from taking a request word until its
// response is placed in the output register. Insert at position p shifts the
// entries from p on one place up and writes the value at p; delete shifts the
// entries after p one place down and writes zero at the last entry; read fetches
// entry p; search walks from entry 1 to the first hit or the end; reverse swaps
// the pairs from both ends inward; a bad position or unknown code goes straight
// to the response. The single RAM read port sets the pace: shifts and searches
// go one entry per cycle; a reverse reads the low and then the high entry of each
// pair and writes them back swapped. No clearing pass
// is needed after reset: one flag per entry marks it as written, and an entry
// never written reads as zero. A finished response sits in an output register,
// so a new request is taken while the previous response still waits.

module positional_array_table_core #(
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [pat_pkg::OP_W-1:0]     operation,
	input  wire logic [pat_pkg::POS_W-1:0]    position,
	input  wire logic signed [pat_pkg::DATA_W-1:0] value,

	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic                              found,
	output logic      [pat_pkg::POS_W-1:0]    found_position,
	output logic signed [pat_pkg::DATA_W-1:0] read_value,
	output logic                              position_error
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned HALF = DEPTH / 2;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [AW-1:0] HALF_LAST = AW'(HALF - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_READ_W,
		ST_MOVE,
		ST_FIN,
		ST_REV,
		ST_REV_FIN,
		ST_SRCH,
		ST_RES
	} state_t;

	state_t state_q;

	// Request held for the whole operation
	logic [AW-1:0]                 slot_q;
	logic [pat_pkg::DATA_W-1:0]    val_q;

	// Walk over the table
	logic [AW-1:0]                 src_q;
	logic [AW-1:0]                 end_q;
	logic                          more_q;
	logic                          up_q;

	// Reverse pair bookkeeping
	logic [AW-1:0]                 lo_q;
	logic [1:0]                    ph_q;
	logic [pat_pkg::DATA_W-1:0]    tmp_q;
	logic                          pend_q;
	logic [AW-1:0]                 bhi_q;

	// Read issued last cycle
	logic                          rd_pend_s1;
	logic [AW-1:0]                 raddr_s1;
	logic                          rvld_s1;

	// Written flags, one per entry
	logic [DEPTH-1:0]              valid_q;

	// Response being built, and the output register
	logic                          res_found_q;
	logic [pat_pkg::POS_W-1:0]     res_pos_q;
	logic [pat_pkg::DATA_W-1:0]    res_rd_q;
	logic                          res_err_q;
	logic                          out_vld_q;
	logic                          found_q;
	logic [pat_pkg::POS_W-1:0]     found_pos_q;
	logic [pat_pkg::DATA_W-1:0]    read_value_q;
	logic                          pos_err_q;

	// RAM port
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [pat_pkg::DATA_W-1:0]    ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [pat_pkg::DATA_W-1:0]    ram_rdata;

	logic [pat_pkg::DATA_W-1:0]    rdata_eff;
	logic [AW-1:0]                 hi_addr;
	logic                          pos_ok;
	logic [AW-1:0]                 slot_n;
	logic                          out_free;

	pat_ram #(
		.WIDTH (pat_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// An entry never written reads as zero
	assign rdata_eff = rvld_s1 ? ram_rdata : '0;
	assign hi_addr   = AW'(DEPTH - 1 - 32'(lo_q));
	assign pos_ok    = (position != '0) && (32'(position) <= DEPTH);
	assign slot_n    = AW'(32'(position) - 32'd1);
	assign out_free  = !out_vld_q || !rsp_stall;

	assign req_stall      = (state_q != ST_IDLE);
	assign rsp_valid      = out_vld_q;
	assign found          = found_q;
	assign found_position = found_pos_q;
	assign read_value     = read_value_q;
	assign position_error = pos_err_q;

	// Drive the RAM from the current step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_READ: begin
				ram_re    = 1'b1;
				ram_raddr = slot_q;
			end
			ST_MOVE: begin
				// write back the word read last cycle one place up or down
				if (rd_pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = up_q ? AW'(32'(raddr_s1) + 32'd1)
					                 : AW'(32'(raddr_s1) - 32'd1);
					ram_wdata = rdata_eff;
				end
				if (more_q) begin
					ram_re    = 1'b1;
					ram_raddr = src_q;
				end
			end
			ST_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = up_q ? slot_q : LAST;
				ram_wdata = up_q ? val_q : '0;
			end
			ST_REV: begin
				case (ph_q)
					2'd0: begin
						ram_re    = 1'b1;
						ram_raddr = lo_q;
						// finish the previous pair
						if (pend_q) begin
							ram_we    = 1'b1;
							ram_waddr = bhi_q;
							ram_wdata = tmp_q;
						end
					end
					2'd1: begin
						ram_re    = 1'b1;
						ram_raddr = hi_addr;
					end
					2'd2: begin
						ram_we    = 1'b1;
						ram_waddr = lo_q;
						ram_wdata = rdata_eff;
					end
					default: begin
					end
				endcase
			end
			ST_REV_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = bhi_q;
				ram_wdata = tmp_q;
			end
			ST_SRCH: begin
				if (more_q) begin
					ram_re    = 1'b1;
					ram_raddr = src_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Read pipeline stage and written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			rvld_s1    <= 1'b0;
			valid_q    <= '0;
		end else begin
			rd_pend_s1 <= ram_re;
			if (ram_re) begin
				rvld_s1 <= valid_q[ram_raddr];
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			raddr_s1 <= ram_raddr;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			more_q    <= 1'b0;
			up_q      <= 1'b0;
			ph_q      <= 2'd0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// drop the response word once taken, unless a new one replaces it
			if (out_vld_q && !rsp_stall && (state_q != ST_RES)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						val_q       <= value;
						slot_q      <= slot_n;
						res_found_q <= 1'b0;
						res_pos_q   <= '0;
						res_rd_q    <= '0;
						res_err_q   <= !pos_ok &&
						               ((operation == pat_pkg::OP_INSERT) ||
						                (operation == pat_pkg::OP_DELETE) ||
						                (operation == pat_pkg::OP_READ));
						case (operation)
							pat_pkg::OP_INSERT: begin
								if (!pos_ok) begin
									state_q   <= ST_RES;
								end else begin
									up_q    <= 1'b1;
									src_q   <= LAST - AW'(1);
									end_q   <= slot_n;
									more_q  <= (slot_n != LAST);
									state_q <= ST_MOVE;
								end
							end
							pat_pkg::OP_DELETE: begin
								if (!pos_ok) begin
									state_q   <= ST_RES;
								end else begin
									up_q    <= 1'b0;
									src_q   <= AW'(32'(slot_n) + 32'd1);
									end_q   <= LAST;
									more_q  <= (slot_n != LAST);
									state_q <= ST_MOVE;
								end
							end
							pat_pkg::OP_READ: begin
								if (!pos_ok) begin
									state_q   <= ST_RES;
								end else begin
									state_q <= ST_READ;
								end
							end
							pat_pkg::OP_REVERSE: begin
								lo_q    <= '0;
								ph_q    <= 2'd0;
								pend_q  <= 1'b0;
								state_q <= ST_REV;
							end
							pat_pkg::OP_SEARCH: begin
								src_q   <= '0;
								end_q   <= LAST;
								more_q  <= 1'b1;
								state_q <= ST_SRCH;
							end
							default: begin
								// unknown code: answer with all zero
								state_q <= ST_RES;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_READ_W;
				end
				ST_READ_W: begin
					res_rd_q <= rdata_eff;
					state_q  <= ST_RES;
				end
				ST_MOVE: begin
					if (more_q) begin
						src_q <= up_q ? AW'(32'(src_q) - 32'd1)
						              : AW'(32'(src_q) + 32'd1);
						if (src_q == end_q) begin
							more_q <= 1'b0;
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_RES;
				end
				ST_REV: begin
					case (ph_q)
						2'd0: begin
							pend_q <= 1'b0;
							ph_q   <= 2'd1;
						end
						2'd1: begin
							tmp_q <= rdata_eff;
							ph_q  <= 2'd2;
						end
						2'd2: begin
							pend_q <= 1'b1;
							bhi_q  <= hi_addr;
							ph_q   <= 2'd0;
							if (lo_q == HALF_LAST) begin
								state_q <= ST_REV_FIN;
							end else begin
								lo_q <= AW'(32'(lo_q) + 32'd1);
							end
						end
						default: begin
							ph_q <= 2'd0;
						end
					endcase
				end
				ST_REV_FIN: begin
					pend_q  <= 1'b0;
					state_q <= ST_RES;
				end
				ST_SRCH: begin
					if (more_q) begin
						src_q <= AW'(32'(src_q) + 32'd1);
					end
					// stop at the first hit
					if (rd_pend_s1 && (rdata_eff == val_q)) begin
						res_found_q <= 1'b1;
						res_pos_q   <= pat_pkg::POS_W'(32'(raddr_s1) + 32'd1);
						more_q      <= 1'b0;
						state_q     <= ST_RES;
					end else if (more_q) begin
						if (src_q == end_q) begin
							more_q <= 1'b0;
						end
					end else if (!rd_pend_s1) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					// hold until the output register is free
					if (out_free) begin
						out_vld_q    <= 1'b1;
						found_q      <= res_found_q;
						found_pos_q  <= res_pos_q;
						read_value_q <= res_rd_q;
						pos_err_q    <= res_err_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The table must not change while no request is in progress
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("table written while idle");

	// Reads and writes in one cycle never touch the same entry
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("read and write to the same entry in one cycle");

	// Writes stay inside the table
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(ram_waddr) < DEPTH))
		else $error("write beyond the last entry");

	// A new response word comes only out of the response step
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == ST_RES))
		else $error("response raised outside the response step");

	// A rejected position gives no other result
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && pos_err_q) |-> (!found_q && (read_value_q == '0)))
		else $error("position error carries other results");

endmodule

`default_nettype wire
